// ===== rtl/core/tcw_pkg.sv =====
// Shared types, codes and defaults for the text console with wrap and scroll.
package tcw_pkg;

  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 32;
  localparam int KEEP_ROWS_DEF = 16;

  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int RROW_W = 5;
  localparam int RCOL_W = 7;
  localparam int OCOL_W = 7;
  localparam int OROW_W = 5;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic [FUNC_W-1:0] FUNC_PUT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_NEWLINE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

  typedef enum logic [1:0] {
    S_RUN = 2'b01,
    S_CLR = 2'b10
  } state_t;

  // Commands from the top level to the cursor unit.
  typedef struct packed {
    logic put;
    logic newline;
    logic set_vld;
  } cur_cmd_t;

  // Status from the cursor unit.
  typedef struct packed {
    logic cur_vld;
    logic rd_vld;
    logic scroll;
  } cur_stat_t;

endpackage

// ===== rtl/core/tcw_cell_mem.sv =====
// Character cell store: one write port, one registered read port.
module tcw_cell_mem #(
  parameter int DEPTH = tcw_pkg::ROWS_DEF * tcw_pkg::COLS_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [tcw_pkg::CHAR_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [tcw_pkg::CHAR_W-1:0] rdata
);

  logic [tcw_pkg::CHAR_W-1:0] mem [DEPTH];
  logic [tcw_pkg::CHAR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/tcw_cursor.sv =====
// Cursor, rotating row base and per-row valid bits of the cell store.
module tcw_cursor #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF,
  parameter int KEEP_ROWS = tcw_pkg::KEEP_ROWS_DEF,
  parameter int CW = $clog2(COLS),
  parameter int RW = $clog2(ROWS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tcw_pkg::cur_cmd_t cmd,
  input  logic [RW-1:0]     set_row,
  input  logic [RW-1:0]     rd_row,
  output logic [CW-1:0]     cur_col,
  output logic [RW-1:0]     cur_row,
  output logic [RW-1:0]     cur_phys,
  output logic [RW-1:0]     rd_phys,
  output tcw_pkg::cur_stat_t stat
);

  localparam int KEEP_EFF = (KEEP_ROWS < ROWS) ? KEEP_ROWS : ROWS - 1;
  localparam int SHIFT = ROWS - KEEP_EFF;

  logic [CW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [RW-1:0]   base_r, base_nxt;
  logic [ROWS-1:0] vld_r, vld_nxt;
  logic [CW:0]     col_inc;
  logic [RW:0]     row_inc;
  logic            wrap, adv_row, scroll;
  logic [RW:0]     cur_sum, rd_sum, base_sum;
  logic [RW:0]     lrow [ROWS];

  // Logical rows map to physical rows through a base that rotates on scroll,
  // so a scroll moves no cells; the rows that fall off are invalidated.
  always_comb begin
    col_inc = {1'b0, col_r} + (CW+1)'(1);
    row_inc = {1'b0, row_r} + (RW+1)'(1);
    wrap = cmd.put && (col_inc >= (CW+1)'(COLS));
    adv_row = cmd.newline || wrap;
    scroll = adv_row && (row_inc >= (RW+1)'(ROWS));

    col_nxt = col_r;
    if (adv_row) begin
      col_nxt = '0;
    end else if (cmd.put) begin
      col_nxt = col_inc[CW-1:0];
    end

    row_nxt = row_r;
    if (scroll) begin
      row_nxt = RW'(KEEP_EFF);
    end else if (adv_row) begin
      row_nxt = row_inc[RW-1:0];
    end

    base_sum = {1'b0, base_r} + (RW+1)'(SHIFT);
    if (base_sum >= (RW+1)'(ROWS)) begin
      base_sum = base_sum - (RW+1)'(ROWS);
    end
    base_nxt = scroll ? base_sum[RW-1:0] : base_r;

    cur_sum = {1'b0, row_r} + {1'b0, base_r};
    if (cur_sum >= (RW+1)'(ROWS)) begin
      cur_sum = cur_sum - (RW+1)'(ROWS);
    end
    rd_sum = {1'b0, rd_row} + {1'b0, base_r};
    if (rd_sum >= (RW+1)'(ROWS)) begin
      rd_sum = rd_sum - (RW+1)'(ROWS);
    end

    for (int p = 0; p < ROWS; p++) begin
      lrow[p] = (RW+1)'(p) + (RW+1)'(ROWS) - {1'b0, base_sum[RW-1:0]};
      if (lrow[p] >= (RW+1)'(ROWS)) begin
        lrow[p] = lrow[p] - (RW+1)'(ROWS);
      end
      vld_nxt[p] = vld_r[p];
      if (scroll && lrow[p] >= (RW+1)'(KEEP_EFF)) begin
        vld_nxt[p] = 1'b0;
      end
      if (cmd.set_vld && set_row == RW'(p)) begin
        vld_nxt[p] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      base_r <= '0;
      vld_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      base_r <= base_nxt;
      vld_r <= vld_nxt;
    end
  end

  assign cur_col = col_r;
  assign cur_row = row_r;
  assign cur_phys = cur_sum[RW-1:0];
  assign rd_phys = rd_sum[RW-1:0];
  assign stat.cur_vld = vld_r[cur_sum[RW-1:0]];
  assign stat.rd_vld = vld_r[rd_sum[RW-1:0]];
  assign stat.scroll = scroll;

endmodule

// ===== rtl/core/text_console_wrap_scroll.sv =====
// A result passes through a pending register and then the output register.
// One transaction per cycle while the output is not stalled; a put into a row not written since reset
// or since it scrolled off zeroes that row first on the write port, and no input is taken meanwhile.
// A scroll itself writes no cells: it rotates the row mapping.
// Reset (synchronous, active low) clears the cursor and all row valid bits;
// there is no clearing pass over the cell store.
module text_console_wrap_scroll #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF,
  parameter int KEEP_ROWS = tcw_pkg::KEEP_ROWS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // char_code[7:0], read_row[12:8], read_col[19:13], zero fill [23:20]
  input  logic [tcw_pkg::IN_DATA_W-1:0]      in_tdata,
  // func[1:0]
  input  logic [tcw_pkg::FUNC_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // cell_char[7:0], cursor_col[14:8], cursor_row[19:15], scrolled[20], zero fill [23:21]
  output logic [tcw_pkg::OUT_DATA_W-1:0]     out_tdata
);

  localparam int CW = $clog2(COLS);
  localparam int RW = $clog2(ROWS);
  localparam int DEPTH = ROWS * COLS;
  localparam int AW = $clog2(DEPTH);
  localparam int KEEP_EFF = (KEEP_ROWS < ROWS) ? KEEP_ROWS : ROWS - 1;

  tcw_pkg::state_t state_r, state_nxt;
  tcw_pkg::cur_cmd_t cmd;
  tcw_pkg::cur_stat_t stat;

  logic [tcw_pkg::CHAR_W-1:0] in_char;
  logic [tcw_pkg::RROW_W-1:0] in_rrow;
  logic [tcw_pkg::RCOL_W-1:0] in_rcol;
  logic acc, put_acc, nl_acc, rd_acc, rd_in_range, out_free, p_move;

  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row, cur_phys, rd_phys;

  logic [RW-1:0] clr_phys_r, clr_phys_nxt;
  logic [CW-1:0] clr_col_r, clr_col_nxt, tgt_col_r, tgt_col_nxt;
  logic [tcw_pkg::CHAR_W-1:0] ch_r, ch_nxt;
  logic clr_last;

  logic we, re;
  logic [AW-1:0] waddr, raddr;
  logic [tcw_pkg::CHAR_W-1:0] wdata, rdata;

  logic p_vld_r, p_vld_nxt, p_rd_r, p_rd_nxt, p_scr_r, p_scr_nxt;
  logic out_vld_r, out_vld_nxt;
  logic [tcw_pkg::CHAR_W-1:0] o_char_r, o_char_nxt;
  logic [tcw_pkg::OCOL_W-1:0] o_col_r, o_col_nxt;
  logic [tcw_pkg::OROW_W-1:0] o_row_r, o_row_nxt;
  logic o_scr_r, o_scr_nxt;

  assign in_char = in_tdata[7:0];
  assign in_rrow = in_tdata[12:8];
  assign in_rcol = in_tdata[19:13];

  assign out_free = !out_vld_r || out_tready;
  assign p_move = p_vld_r && out_free;
  assign in_tready = (state_r == tcw_pkg::S_RUN) && (!p_vld_r || out_free);
  assign acc = in_tvalid && in_tready;
  assign put_acc = acc && (in_tuser == tcw_pkg::FUNC_PUT);
  assign nl_acc = acc && (in_tuser == tcw_pkg::FUNC_NEWLINE);
  assign rd_acc = acc && (in_tuser == tcw_pkg::FUNC_READ);
  assign rd_in_range = (32'(in_rrow) < ROWS) && (32'(in_rcol) < COLS);
  assign clr_last = (clr_col_r == CW'(COLS - 1));

  assign cmd.put = put_acc;
  assign cmd.newline = nl_acc;
  assign cmd.set_vld = (state_r == tcw_pkg::S_CLR) && clr_last;

  tcw_cursor #(
    .COLS(COLS),
    .ROWS(ROWS),
    .KEEP_ROWS(KEEP_ROWS),
    .CW(CW),
    .RW(RW)
  ) u_cursor (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .set_row(clr_phys_r),
    .rd_row(RW'(in_rrow)),
    .cur_col(cur_col),
    .cur_row(cur_row),
    .cur_phys(cur_phys),
    .rd_phys(rd_phys),
    .stat(stat)
  );

  tcw_cell_mem #(
    .DEPTH(DEPTH),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .we(we),
    .waddr(waddr),
    .wdata(wdata),
    .re(re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    state_nxt = state_r;
    clr_phys_nxt = clr_phys_r;
    clr_col_nxt = clr_col_r;
    tgt_col_nxt = tgt_col_r;
    ch_nxt = ch_r;
    we = 1'b0;
    waddr = AW'(AW'(cur_phys) * AW'(COLS)) + AW'(cur_col);
    wdata = in_char;

    unique case (state_r)
      tcw_pkg::S_RUN: begin
        if (put_acc) begin
          if (stat.cur_vld) begin
            we = 1'b1;
          end else begin
            // First write into a stale row: zero the whole row, dropping the
            // new character in on the way.
            state_nxt = tcw_pkg::S_CLR;
            clr_phys_nxt = cur_phys;
            clr_col_nxt = '0;
            tgt_col_nxt = cur_col;
            ch_nxt = in_char;
          end
        end
      end
      tcw_pkg::S_CLR: begin
        we = 1'b1;
        waddr = AW'(AW'(clr_phys_r) * AW'(COLS)) + AW'(clr_col_r);
        wdata = (clr_col_r == tgt_col_r) ? ch_r : '0;
        clr_col_nxt = clr_col_r + CW'(1);
        if (clr_last) begin
          state_nxt = tcw_pkg::S_RUN;
        end
      end
      default: begin
        state_nxt = tcw_pkg::S_RUN;
      end
    endcase
  end

  assign re = rd_acc && rd_in_range;
  assign raddr = AW'(AW'(rd_phys) * AW'(COLS)) + AW'(CW'(in_rcol));

  always_comb begin
    p_vld_nxt = p_vld_r;
    p_rd_nxt = p_rd_r;
    p_scr_nxt = p_scr_r;
    if (acc) begin
      p_vld_nxt = 1'b1;
      p_rd_nxt = re && stat.rd_vld;
      p_scr_nxt = stat.scroll;
    end else if (p_move) begin
      p_vld_nxt = 1'b0;
    end

    out_vld_nxt = out_vld_r;
    o_char_nxt = o_char_r;
    o_col_nxt = o_col_r;
    o_row_nxt = o_row_r;
    o_scr_nxt = o_scr_r;
    if (p_move) begin
      // The cursor registers already hold the state after the pending item.
      out_vld_nxt = 1'b1;
      o_char_nxt = p_rd_r ? rdata : '0;
      o_col_nxt = tcw_pkg::OCOL_W'(cur_col);
      o_row_nxt = tcw_pkg::OROW_W'(cur_row);
      o_scr_nxt = p_scr_r;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcw_pkg::S_RUN;
      p_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p_vld_r <= p_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    clr_phys_r <= clr_phys_nxt;
    clr_col_r <= clr_col_nxt;
    tgt_col_r <= tgt_col_nxt;
    ch_r <= ch_nxt;
    p_rd_r <= p_rd_nxt;
    p_scr_r <= p_scr_nxt;
    o_char_r <= o_char_nxt;
    o_col_r <= o_col_nxt;
    o_row_r <= o_row_nxt;
    o_scr_r <= o_scr_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata = {3'b000, o_scr_r, o_row_r, o_col_r, o_char_r};

  // No new transaction is taken while a row is being zeroed.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::S_CLR) |-> !in_tready)
    else $error("input taken during row clear");

  // A pending result that cannot move blocks the input.
  assert property (@(posedge clk) disable iff (!rst_n)
    (p_vld_r && !out_free) |-> !in_tready)
    else $error("pending result overrun");

  // A scroll always leaves the cursor at column zero of the first cleared row.
  assert property (@(posedge clk) disable iff (!rst_n)
    (p_move && p_scr_r) |=> (o_scr_r && o_row_r == tcw_pkg::OROW_W'(KEEP_EFF) &&
                             o_col_r == '0))
    else $error("bad cursor after scroll");

  // The row clear always starts at column zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == tcw_pkg::S_CLR) |-> (clr_col_r == '0))
    else $error("row clear started mid-row");

endmodule
